>>> sv/wswor_pkg.sv
// Package for the weighted sampler without replacement.
// Holds the transaction payload types, the operation and register codes,
// and the command and status bundles between the controller and datapath.
package wswor_pkg;

    // Operation codes of an input transaction
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PICK  = 1'b1;

    // Configuration register indexes and reset values
    localparam int          CFG_IDX_W          = 8;
    localparam int          CFG_DATA_W         = 8;
    localparam logic [7:0]  CFG_POOL_SIZE      = 8'd0;
    localparam logic [7:0]  CFG_PICKS_PER_DRAW = 8'd1;
    localparam logic [7:0]  POOL_SIZE_RST      = 8'd90;
    localparam logic [7:0]  PICKS_PER_DRAW_RST = 8'd6;

    // Input transaction
    typedef struct packed {
        logic        operation;
        logic [6:0]  entry_index;
        logic [15:0] weight_value;
        logic [31:0] random_fraction;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [7:0] picked_number;
        logic       last_of_draw;
        logic       fallback_used;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic take_write;
        logic take_pick;
        logic sum_step;
        logic mul;
        logic srch_step;
        logic mark;
        logic emit;
        logic sweep;
        logic sweep_wt;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_pick;
        logic scan_done;
        logic total_zero;
        logic found;
        logic last;
        logic out_free;
        logic sweep_last;
    } t_status;

endpackage

>>> sv/weighted_sampler_without_replacement_unit.sv
// Operation: a weight write is taken in the idle state; a pick runs two scans of the weight
// memory (one on a zero total) over an active pool of N entries, at one entry per cycle.
// Throughput: one item at a time; the next is taken once the result is registered.
// The pick that ends a draw is followed by a sweep that clears the mark memory.
// Reset is synchronous, active low; afterwards a sweep zeroes the
// weights and marks, and no item is taken until it ends (configuration is).
module weighted_sampler_without_replacement_unit #(
    parameter int MAX_POOL = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wswor_pkg::t_in_item               i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wswor_pkg::t_out_item              o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wswor_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wswor_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wswor_pkg::*;

    t_cmd    cmd;
    t_status st;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    wswor_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    wswor_dp #(
        .MAX_POOL (MAX_POOL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> sv/wswor_ctrl.sv
// Controller of the weighted sampler without replacement.
// Sequences the clearing sweep, the two pool scans, marking and output.
// Depends on wswor_pkg for the command and status bundles.
module wswor_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wswor_pkg::t_status i_st,
    output wswor_pkg::t_cmd    o_cmd
);
    import wswor_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SRCH = 3'd4;
    localparam logic [2:0] S_MARK = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;
    localparam logic [2:0] S_CLR  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep    = 1'b1;
                o_cmd.sweep_wt = 1'b1;
                if (i_st.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_st.is_pick) begin
                        o_cmd.take_pick = 1'b1;
                        n_state         = S_SUM;
                    end else begin
                        o_cmd.take_write = 1'b1;
                    end
                end
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_st.scan_done) begin
                    n_state = i_st.total_zero ? S_MARK : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SRCH;
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_st.found || i_st.scan_done) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_st.last ? S_CLR : S_IDLE;
                end
            end
            S_CLR: begin
                o_cmd.sweep = 1'b1;
                if (i_st.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/wswor_dp.sv
// Datapath of the weighted sampler without replacement.
// Holds the weight and mark memories, scan accumulators, the target
// multiplier, configuration registers and the output register. Uses wswor_pkg.
module wswor_dp #(
    parameter int MAX_POOL = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  wswor_pkg::t_cmd                        i_cmd,
    output wswor_pkg::t_status                     o_st,
    input  wswor_pkg::t_in_item                    i_in_item,
    input  logic                                   i_cfg_valid,
    input  logic [wswor_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wswor_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output wswor_pkg::t_out_item                   o_out_item
);
    import wswor_pkg::*;

    localparam int AW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int CW = $clog2(MAX_POOL + 1);
    localparam int SW = 16 + AW;
    localparam int TW = SW + 32;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POOL - 1);

    // Memories
    logic [15:0] wt_mem [MAX_POOL];
    logic        mk_mem [MAX_POOL];

    // Configuration
    logic [7:0]    r_pool_size;
    logic [7:0]    r_picks_per_draw;
    logic [CW-1:0] act_n;
    logic [CW-1:0] need;

    // Scan control
    logic [CW-1:0] r_addr;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic [AW-1:0] rd_addr;
    logic          scan_step;
    logic          issue;
    logic [15:0]   r_wt_q;
    logic          r_mk_q;

    // Accumulators and choices
    logic [31:0]   r_u;
    logic [SW-1:0] r_total;
    logic [SW-1:0] r_cum;
    logic [SW-1:0] cum_nx;
    logic [TW-1:0] r_target;
    logic          r_any;
    logic          r_found;
    logic [AW-1:0] r_first;
    logic [AW-1:0] r_lastfree;
    logic [AW-1:0] r_chosen;
    logic          sum_proc;
    logic          srch_proc;
    logic          srch_hit;
    logic          total_zero;
    logic [AW-1:0] sel;
    logic          sel_fb;
    logic [CW-1:0] r_picks;
    logic          pick_last;
    t_out_item     r_res;
    t_out_item     r_out;
    logic          r_out_valid;

    // Clearing sweep
    logic [AW-1:0] r_sw_addr;

    // Memory ports
    logic          wt_we;
    logic [AW-1:0] wt_wa;
    logic [15:0]   wt_wd;
    logic          mk_we;
    logic [AW-1:0] mk_wa;
    logic          mk_wd;

    // Clamp pool size and picks per draw
    always_comb begin
        if (r_pool_size == '0) begin
            act_n = CW'(1);
        end else if (32'(r_pool_size) > 32'(MAX_POOL)) begin
            act_n = CW'(MAX_POOL);
        end else begin
            act_n = CW'(r_pool_size);
        end
        if (r_picks_per_draw == '0) begin
            need = CW'(1);
        end else if (32'(r_picks_per_draw) > 32'(act_n)) begin
            need = act_n;
        end else begin
            need = CW'(r_picks_per_draw);
        end
    end

    // Scan addressing: one entry read per cycle, its data registered for the next cycle
    assign scan_step = i_cmd.sum_step | (i_cmd.srch_step & ~r_found);
    assign issue     = scan_step & (r_addr < act_n);
    assign rd_addr   = r_addr[AW-1:0];

    assign sum_proc  = i_cmd.sum_step & r_rd_vld & ~r_mk_q;
    assign srch_proc = i_cmd.srch_step & r_rd_vld & ~r_found & ~r_mk_q;
    assign cum_nx    = r_cum + SW'(r_wt_q);
    assign srch_hit  = srch_proc & ({cum_nx, 32'd0} >= r_target);

    // Final choice
    assign total_zero = (r_total == '0);
    assign sel        = total_zero ? r_first : (r_found ? r_chosen : r_lastfree);
    assign sel_fb     = total_zero | ~r_found;
    assign pick_last  = ~r_any | ((r_picks + CW'(1)) >= need);

    // Memory write selection
    always_comb begin
        if (i_cmd.sweep_wt) begin
            wt_we = 1'b1;
            wt_wa = r_sw_addr;
            wt_wd = '0;
        end else begin
            wt_we = i_cmd.take_write & (32'(i_in_item.entry_index) < 32'(MAX_POOL));
            wt_wa = AW'(i_in_item.entry_index);
            wt_wd = i_in_item.weight_value;
        end
        if (i_cmd.sweep) begin
            mk_we = 1'b1;
            mk_wa = r_sw_addr;
            mk_wd = 1'b0;
        end else begin
            mk_we = i_cmd.mark & r_any;
            mk_wa = sel;
            mk_wd = 1'b1;
        end
    end

    // Weight memory
    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            wt_mem[wt_wa] <= wt_wd;
        end
        r_wt_q <= wt_mem[rd_addr];
    end

    // Mark memory
    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            mk_mem[mk_wa] <= mk_wd;
        end
        r_mk_q <= mk_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size      <= POOL_SIZE_RST;
            r_picks_per_draw <= PICKS_PER_DRAW_RST;
            r_addr           <= '0;
            r_rd_vld         <= 1'b0;
            r_any            <= 1'b0;
            r_found          <= 1'b0;
            r_picks          <= '0;
            r_sw_addr        <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_POOL_SIZE) begin
                    r_pool_size <= i_cfg_data;
                end else if (i_cfg_index == CFG_PICKS_PER_DRAW) begin
                    r_picks_per_draw <= i_cfg_data;
                end
            end
            // Restart or advance the scan
            if (i_cmd.take_pick || i_cmd.mul) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else begin
                if (issue) begin
                    r_addr <= r_addr + CW'(1);
                end
                r_rd_vld <= issue;
            end
            if (i_cmd.take_pick) begin
                r_any <= 1'b0;
            end else if (sum_proc) begin
                r_any <= 1'b1;
            end
            if (i_cmd.take_pick || i_cmd.mul) begin
                r_found <= 1'b0;
            end else if (srch_hit) begin
                r_found <= 1'b1;
            end
            // Count picks of the draw
            if (i_cmd.mark) begin
                r_picks <= pick_last ? '0 : r_picks + CW'(1);
            end
            // Advance the clearing sweep
            if (i_cmd.sweep) begin
                r_sw_addr <= (r_sw_addr == LAST_ADDR) ? '0 : r_sw_addr + AW'(1);
            end
            // Hold the result until taken
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;
        if (i_cmd.take_pick) begin
            r_u     <= i_in_item.random_fraction;
            r_total <= '0;
        end else if (sum_proc) begin
            r_total    <= r_total + SW'(r_wt_q);
            r_lastfree <= r_rd_idx;
            if (!r_any) begin
                r_first <= r_rd_idx;
            end
        end
        if (i_cmd.mul) begin
            r_target <= TW'(r_u) * TW'(r_total);
            r_cum    <= '0;
        end else if (srch_proc) begin
            r_cum <= cum_nx;
        end
        if (srch_hit) begin
            r_chosen <= r_rd_idx;
        end
        if (i_cmd.mark) begin
            r_res.picked_number <= r_any ? 8'({1'b0, sel} + 1'b1) : 8'd1;
            r_res.last_of_draw  <= pick_last;
            r_res.fallback_used <= ~r_any | sel_fb;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    // Status
    assign o_st.is_pick    = (i_in_item.operation == OP_PICK);
    assign o_st.scan_done  = (r_addr == act_n) & ~r_rd_vld;
    assign o_st.total_zero = total_zero;
    assign o_st.found      = r_found;
    assign o_st.last       = r_res.last_of_draw;
    assign o_st.out_free   = ~r_out_valid | i_out_ready;
    assign o_st.sweep_last = (r_sw_addr == LAST_ADDR);

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> tb/wswor_draw_checker.sv
// Checker for the weighted sampler without replacement.
// Watches the input, result and register channels, predicts every pick and
// compares the result stream. Depends on wswor_pkg.
module wswor_draw_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  wswor_pkg::t_in_item               i_in_item,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  wswor_pkg::t_out_item              i_out_item,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [wswor_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wswor_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                o_mismatches,
    output int                                o_outstanding
);
    import wswor_pkg::*;

    localparam int POOL_DEPTH = 128;

    // Shadow of the pool, the current draw and the registers
    logic [15:0] weights [POOL_DEPTH];
    logic        picked  [POOL_DEPTH];
    int          picks_in_draw;
    logic [7:0]  pool_size_reg;
    logic [7:0]  picks_per_draw_reg;
    t_out_item   expected_picks [$];

    // Drop every mark and start a fresh draw
    function automatic void clear_marks();
        for (int i = 0; i < POOL_DEPTH; i++) picked[i] = 1'b0;
        picks_in_draw = 0;
    endfunction

    // Roulette-wheel choice over the unpicked entries of the active pool
    function automatic t_out_item predict_pick(input logic [31:0] frac);
        int          n;
        int          need;
        int          first;
        int          last_free;
        int          chosen;
        logic [63:0] total;
        logic [63:0] target;
        logic [63:0] running;
        t_out_item   res;
        n = (pool_size_reg == 8'd0) ? 1 :
            ((pool_size_reg > POOL_DEPTH) ? POOL_DEPTH : int'(pool_size_reg));
        need = (picks_per_draw_reg == 8'd0) ? 1 : int'(picks_per_draw_reg);
        if (need > n) need = n;
        total     = '0;
        running   = '0;
        first     = -1;
        last_free = -1;
        chosen    = -1;
        res       = '0;
        for (int i = 0; i < n; i++) begin
            if (!picked[i]) begin
                total = total + weights[i];
                if (first < 0) first = i;
                last_free = i;
            end
        end
        // Nothing left in range: report entry one with both flags, restart the draw
        if (first < 0) begin
            clear_marks();
            res.picked_number = 8'd1;
            res.last_of_draw  = 1'b1;
            res.fallback_used = 1'b1;
            return res;
        end
        if (total == 64'd0) begin
            chosen            = first;
            res.fallback_used = 1'b1;
        end else begin
            target = 64'(frac) * total;
            for (int i = 0; i < n && chosen < 0; i++) begin
                if (!picked[i]) begin
                    running = running + weights[i];
                    if ((running << 32) >= target) chosen = i;
                end
            end
            if (chosen < 0) begin
                chosen            = last_free;
                res.fallback_used = 1'b1;
            end
        end
        picked[chosen] = 1'b1;
        picks_in_draw++;
        if (picks_in_draw >= need) begin
            res.last_of_draw = 1'b1;
            clear_marks();
        end
        res.picked_number = 8'(chosen + 1);
        return res;
    endfunction

    // Follow every transaction; results are handled before new items
    always @(posedge i_clk) begin : track
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_DEPTH; i++) weights[i] = '0;
            clear_marks();
            pool_size_reg      = POOL_SIZE_RST;
            picks_per_draw_reg = PICKS_PER_DRAW_RST;
            expected_picks.delete();
            o_mismatches       = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POOL_SIZE:      pool_size_reg      = i_cfg_data;
                    CFG_PICKS_PER_DRAW: picks_per_draw_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_picks.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display({"ERROR %0t: result with none expected: ",
                                  "number=%0d last=%0b fb=%0b"},
                                 $time, i_out_item.picked_number, i_out_item.last_of_draw,
                                 i_out_item.fallback_used);
                end else begin
                    want = expected_picks.pop_front();
                    if (i_out_item.picked_number !== want.picked_number ||
                        i_out_item.last_of_draw  !== want.last_of_draw  ||
                        i_out_item.fallback_used !== want.fallback_used) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display({"ERROR %0t: pick differs: expected number=%0d last=%0b ",
                                      "fb=%0b, got number=%0d last=%0b fb=%0b"},
                                     $time, want.picked_number, want.last_of_draw,
                                     want.fallback_used, i_out_item.picked_number,
                                     i_out_item.last_of_draw, i_out_item.fallback_used);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.operation == OP_WRITE)
                    weights[i_in_item.entry_index] = i_in_item.weight_value;
                else
                    expected_picks.push_back(predict_pick(i_in_item.random_fraction));
            end
        end
        o_outstanding = expected_picks.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the weighted sampler testbench: clock, reset, stimulus and verdict.
// Instantiates weighted_sampler_without_replacement_unit and wswor_draw_checker;
// depends on wswor_pkg.
module testbench;
    import wswor_pkg::*;

    localparam int                   RUN_LIMIT        = 30_000_000;
    localparam int                   IDLE_MARGIN      = 400;
    localparam int                   LONG_HOLD_CYCLES = 600;
    localparam int                   PHASES           = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 8'hC3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatch_count;
    int                    outstanding;
    logic                  steady_flow;
    int                    hold_requests;

    // Register settings per random phase, extremes included
    int pool_plan [PHASES] = '{1, 5, 8, 16, 0, 3, 128, 255, 30, 12, 90, 64};
    int draw_plan [PHASES] = '{1, 5, 255, 0, 1, 128, 128, 7, 3, 12, 6, 200};

    weighted_sampler_without_replacement_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    wswor_draw_checker draw_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatch_count),
        .o_outstanding (outstanding)
    );

    initial begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : run_limit
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] weight_for(input int style);
        case (style)
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 3));
            2:       return ($urandom_range(0, 99) < 85) ? 16'd0 :
                            16'($urandom_range(1, 65535));
            default: return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_fraction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'h0;
        if (r < 10) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // Offer one transaction, starting and ending on a falling edge
    task automatic drive_item(input t_in_item it);
        int gap;
        gap = steady_flow ? 0 : draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_weight(input logic [6:0] idx, input logic [15:0] w);
        t_in_item it;
        it.operation       = OP_WRITE;
        it.entry_index     = idx;
        it.weight_value    = w;
        it.random_fraction = $urandom();
        drive_item(it);
    endtask

    task automatic pick(input logic [31:0] u);
        t_in_item it;
        it.operation       = OP_PICK;
        it.entry_index     = 7'($urandom_range(0, 127));
        it.weight_value    = 16'($urandom_range(0, 65535));
        it.random_fraction = u;
        drive_item(it);
    endtask

    // Hold valid high across back-to-back register writes
    task automatic offer_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_registers(input logic [7:0] pool, input logic [7:0] picks);
        offer_register(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom_range(0, 255)));
        offer_register(CFG_POOL_SIZE, pool);
        offer_register(CFG_PICKS_PER_DRAW, picks);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, let every result drain, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (IDLE_MARGIN) @(negedge clk);
    endtask

    // Result side: random ready, with steady stretches and one long hold-off
    initial begin : result_sink
        int run;
        int holds_done;
        out_ready  = 1'b0;
        run        = 0;
        holds_done = 0;
        forever begin
            @(negedge clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                run = 0;
            end else if (steady_flow) begin
                out_ready <= 1'b1;
            end else if (run > 0) begin
                run--;
            end else if ($urandom_range(0, 99) < 65) begin
                out_ready <= 1'b1;
                run = $urandom_range(0, 7);
            end else begin
                out_ready <= 1'b0;
                run = draw_gap();
            end
        end
    end

    initial begin : stimulus
        int p;
        int k;
        int n;
        int budget;
        int style;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        steady_flow   = 1'b0;
        hold_requests = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty pool falls back to the first free entry
        pick(32'h0);
        pick(32'hFFFF_FFFF);
        put_weight(7'd0, 16'd0);
        put_weight(7'd2, 16'd0);
        put_weight(7'd3, 16'hFFFF);
        put_weight(7'd127, 16'hFFFF);
        put_weight(7'd89, 16'd1);
        // Zero weight still qualifies for a zero fraction
        pick(32'h0);
        pick(32'hFFFF_FFFF);
        pick(32'h8000_0000);
        // Only zero weights left: fallback on the pick that ends the draw
        pick(32'h1234_5678);
        wait_idle();

        // Shrink the pool mid-draw so that no free entry is left
        write_registers(8'd4, 8'd4);
        for (k = 0; k < 4; k++) put_weight(7'(k), 16'd1);
        pick(32'h0);
        pick(32'h0);
        wait_idle();
        write_registers(8'd2, 8'd4);
        pick(32'h0);
        pick(32'h0);
        pick(32'hFFFF_FFFF);
        wait_idle();

        // Random phases over the planned settings
        for (p = 0; p < PHASES; p++) begin
            write_registers(8'(pool_plan[p]), 8'(draw_plan[p]));
            n = (pool_plan[p] == 0) ? 1 : ((pool_plan[p] > 128) ? 128 : pool_plan[p]);
            style       = p % 4;
            steady_flow = (p % 5 == 3);
            if (p == 1) hold_requests++;
            budget = (n >= 64) ? 50 : 100;
            for (k = 0; k < n && k < 12; k++) put_weight(7'(k), weight_for(style));
            for (k = 0; k < budget; k++) begin
                if ($urandom_range(0, 99) < 30) begin
                    if ($urandom_range(0, 99) < 80)
                        put_weight(7'($urandom_range(0, n - 1)), weight_for(style));
                    else
                        put_weight(7'($urandom_range(0, 127)), weight_for(style));
                end else begin
                    pick(pick_fraction());
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
